// ===== design/generational_handle_allocator_top_macros.svh =====
// Assertion macros for the handle allocator datapath.
// Expects a clock named clk and an active-high synchronous reset named rst in scope.
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define GAH_ASSERT_HOLDS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GAH_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/gah_pkg.sv =====
// Shared types and codes for the generational handle allocator.
// No dependencies; used by the controller, the datapath and the top level.
package gah_pkg;

  // Fixed widths of the transfer fields.
  localparam int CMD_W    = 2;
  localparam int INDEX_W  = 8;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_CREATE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DESTROY = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHECK   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_STALE = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SLOT,
    S_EXEC
  } ctl_state_t;

  // Where the slot of the current operation comes from.
  typedef enum logic [1:0] {
    SRC_POP,
    SRC_FRESH,
    SRC_FULL,
    SRC_HANDLE
  } slot_src_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic slot_read;
    logic execute;
  } ctl_cmd_t;

endpackage

// ===== design/gah_ctrl.sv =====
// Sequencing controller for the handle allocator.
// Depends on gah_pkg for the state type and the command struct.
module gah_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output gah_pkg::ctl_cmd_t ctl
);
  import gah_pkg::*;

  ctl_state_t state;
  ctl_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state: capture, slot read, then execute.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_SLOT;
        end
      end
      S_SLOT: begin
        state_next = S_EXEC;
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    busy          = (state != S_IDLE);
    ctl.capture   = (state == S_IDLE) && start;
    ctl.slot_read = (state == S_SLOT);
    ctl.execute   = (state == S_EXEC);
  end

endmodule

// ===== design/gah_datapath.sv =====
// Datapath of the handle allocator: free stack, slot store and counters.
// Depends on gah_pkg and on the assertion macros header.
module gah_datapath #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  gah_pkg::ctl_cmd_t             ctl,
  input  logic [gah_pkg::CMD_W-1:0]     cmd,
  input  logic [gah_pkg::INDEX_W-1:0]   slot_index,
  input  logic [gah_pkg::TAG_W-1:0]     tag,
  output logic                          done,
  output logic [gah_pkg::STATUS_W-1:0]  status,
  output logic [gah_pkg::INDEX_W-1:0]   out_index,
  output logic [gah_pkg::TAG_W-1:0]     out_tag,
  output logic                          live,
  output logic [gah_pkg::COUNT_W-1:0]   live_count
);
  import gah_pkg::*;

  `include "generational_handle_allocator_top_macros.svh"

  localparam int IDX_W   = $clog2(SLOTS);
  localparam int HW_W    = $clog2(SLOTS + 1);
  localparam int IEXT_W  = (IDX_W > INDEX_W) ? IDX_W : INDEX_W;
  localparam int HCMP_W  = (HW_W > INDEX_W) ? HW_W : INDEX_W;
  localparam int TCMP_W  = (GEN_BITS > TAG_W) ? GEN_BITS : TAG_W;
  localparam int CEXT_W  = (HW_W > COUNT_W) ? HW_W : COUNT_W;
  localparam int SLOT_W  = GEN_BITS + 1;

  // Control state.
  logic [HW_W-1:0] high_water;
  logic [HW_W-1:0] free_top;
  logic [HW_W-1:0] alive_total;
  logic [HW_W-1:0] alive_next;

  // Captured request.
  logic [CMD_W-1:0]   cmd_q;
  logic [INDEX_W-1:0] idx_q;
  logic [TAG_W-1:0]   tag_q;

  // Memories: free stack and per-slot {alive, generation}.
  logic [IDX_W-1:0]  free_stack [SLOTS];
  logic [SLOT_W-1:0] slot_mem   [SLOTS];
  logic [IDX_W-1:0]  stack_rd;
  logic [SLOT_W-1:0] slot_rd;

  // Slot selection registers.
  logic [IDX_W-1:0] addr_q;
  slot_src_t        src_q;

  // Intermediate signals.
  logic [HW_W-1:0]   top_m1;
  logic [IDX_W-1:0]  stack_raddr;
  logic [IEXT_W-1:0] idx_ext;
  logic [IDX_W-1:0]  idx_slot;
  slot_src_t         src_sel;
  logic [IDX_W-1:0]  addr_sel;
  logic [HCMP_W-1:0] idx_cmp;
  logic [HCMP_W-1:0] hw_cmp;
  logic              in_range;
  logic [GEN_BITS-1:0] gen_rd;
  logic              alive_rd;
  logic [GEN_BITS-1:0] gen_inc;
  logic [GEN_BITS-1:0] create_gen;
  logic [TCMP_W-1:0] gen_ext;
  logic [TCMP_W-1:0] create_ext;
  logic              hit;
  logic [IEXT_W-1:0] addr_ext;
  logic              slot_we;
  logic [SLOT_W-1:0] slot_wdata;
  logic              push;
  logic              pop;
  logic              fresh;
  logic [STATUS_W-1:0] res_status;
  logic [INDEX_W-1:0]  res_index;
  logic [TAG_W-1:0]    res_tag;
  logic                res_live;
  logic [CEXT_W-1:0]   count_ext;
  logic [HW_W:0]       used_sum;

  // Index conversions between the 8-bit port field and the slot address.
  always_comb begin
    idx_ext  = IEXT_W'(idx_q);
    idx_slot = idx_ext[IDX_W-1:0];
    idx_cmp  = HCMP_W'(idx_q);
    hw_cmp   = HCMP_W'(high_water);
    in_range = (idx_cmp < hw_cmp);
    top_m1   = free_top - 1'b1;
    stack_raddr = (free_top == '0) ? '0 : top_m1[IDX_W-1:0];
  end

  // Capture the request and read the top of the free stack.
  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      cmd_q    <= cmd;
      idx_q    <= slot_index;
      tag_q    <= tag;
      stack_rd <= free_stack[stack_raddr];
    end
  end

  // Choose the slot: popped index, fresh slot, full, or the given handle.
  always_comb begin
    src_sel  = SRC_HANDLE;
    addr_sel = idx_slot;
    if (cmd_q == CMD_CREATE) begin
      priority if (free_top != '0) begin
        src_sel  = SRC_POP;
        addr_sel = stack_rd;
      end else if (high_water < HW_W'(SLOTS)) begin
        src_sel  = SRC_FRESH;
        addr_sel = high_water[IDX_W-1:0];
      end else begin
        src_sel  = SRC_FULL;
        addr_sel = idx_slot;
      end
    end
  end

  // Slot store read.
  always_ff @(posedge clk) begin
    if (ctl.slot_read) begin
      addr_q  <= addr_sel;
      src_q   <= src_sel;
      slot_rd <= slot_mem[addr_sel];
    end
  end

  // Evaluate the operation against the slot that was read.
  always_comb begin
    gen_rd     = slot_rd[GEN_BITS-1:0];
    alive_rd   = slot_rd[GEN_BITS];
    gen_inc    = gen_rd + 1'b1;
    create_gen = (src_q == SRC_FRESH) ? '0 : gen_rd;
    gen_ext    = TCMP_W'(gen_rd);
    create_ext = TCMP_W'(create_gen);
    hit        = in_range && alive_rd && (gen_ext == TCMP_W'(tag_q));
    addr_ext   = IEXT_W'(addr_q);

    slot_we    = 1'b0;
    slot_wdata = slot_rd;
    push       = 1'b0;
    pop        = 1'b0;
    fresh      = 1'b0;
    alive_next = alive_total;
    res_status = STAT_OK;
    res_index  = idx_q;
    res_tag    = tag_q;
    res_live   = 1'b0;

    unique case (src_q)
      SRC_POP, SRC_FRESH: begin
        slot_we    = 1'b1;
        slot_wdata = {1'b1, create_gen};
        pop        = (src_q == SRC_POP);
        fresh      = (src_q == SRC_FRESH);
        alive_next = alive_total + 1'b1;
        res_index  = addr_ext[INDEX_W-1:0];
        res_tag    = create_ext[TAG_W-1:0];
        res_live   = 1'b1;
      end
      SRC_FULL: begin
        res_status = STAT_FULL;
      end
      SRC_HANDLE: begin
        if (cmd_q == CMD_DESTROY) begin
          if (hit) begin
            slot_we    = 1'b1;
            slot_wdata = {1'b0, gen_inc};
            push       = (free_top < HW_W'(SLOTS));
            if (alive_total != '0) begin
              alive_next = alive_total - 1'b1;
            end
          end else begin
            res_status = STAT_STALE;
          end
        end else begin
          res_live = hit;
        end
      end
      default: begin
        res_status = STAT_OK;
      end
    endcase
  end

  // Slot store write.
  always_ff @(posedge clk) begin
    if (ctl.execute && slot_we) begin
      slot_mem[addr_q] <= slot_wdata;
    end
  end

  // Free stack push.
  always_ff @(posedge clk) begin
    if (ctl.execute && push) begin
      free_stack[free_top[IDX_W-1:0]] <= idx_slot;
    end
  end

  // Counters and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      high_water  <= '0;
      free_top    <= '0;
      alive_total <= '0;
      done        <= 1'b0;
    end else begin
      done <= ctl.execute;
      if (ctl.execute) begin
        alive_total <= alive_next;
        if (pop) begin
          free_top <= top_m1;
        end else if (push) begin
          free_top <= free_top + 1'b1;
        end
        if (fresh) begin
          high_water <= high_water + 1'b1;
        end
      end
    end
  end

  // Result registers.
  always_comb begin
    count_ext = CEXT_W'(alive_next);
  end

  always_ff @(posedge clk) begin
    if (ctl.execute) begin
      status     <= res_status;
      out_index  <= res_index;
      out_tag    <= res_tag;
      live       <= res_live;
      live_count <= count_ext[COUNT_W-1:0];
    end
  end

  // Every slot ever used is either live or on the free stack.
  assign used_sum = (HW_W+1)'(free_top) + (HW_W+1)'(alive_total);

  `GAH_ASSERT_HOLDS(a_count_balance, 1'b1, used_sum == (HW_W+1)'(high_water), "slot count mismatch")
  `GAH_ASSERT_HOLDS(a_full_means_all_live, done && (status == STAT_FULL),
    alive_total == HW_W'(SLOTS), "full reported while slots remain")
  `GAH_ASSERT_NEXT(a_done_single, done, !done, "result strobe held for two cycles")

endmodule

// ===== design/generational_handle_allocator_top.sv =====
// Top level of the generational handle allocator.
// Depends on gah_pkg, gah_ctrl and gah_datapath.
//
//  Channel  | Handshake          | Payload
//  ---------+--------------------+--------------------------------------------
//  request  | start, busy        | cmd, slot_index, tag
//  result   | done (strobe)      | status, out_index, out_tag, live, live_count
//
// A request is taken when start is high and busy is low; busy then stays high
// through the slot-read and execute states, so no new request is taken until
// the last one is through. The wait comes from two dependent memory reads:
// the top of the free stack and then the slot store entry of the chosen slot.
// The result strobe done rises in the same cycle in which busy falls and lasts
// one cycle.
// Synchronous reset empties the stack and counters; slots are valid up to the
// high-water count, so no clearing pass follows reset.
module generational_handle_allocator_top #(
  parameter int SLOTS    = 256,
  parameter int GEN_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [gah_pkg::CMD_W-1:0]     cmd,
  input  logic [gah_pkg::INDEX_W-1:0]   slot_index,
  input  logic [gah_pkg::TAG_W-1:0]     tag,
  output logic                          done,
  output logic [gah_pkg::STATUS_W-1:0]  status,
  output logic [gah_pkg::INDEX_W-1:0]   out_index,
  output logic [gah_pkg::TAG_W-1:0]     out_tag,
  output logic                          live,
  output logic [gah_pkg::COUNT_W-1:0]   live_count
);
  import gah_pkg::*;

  ctl_cmd_t ctl;

  // Sequencer.
  gah_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .ctl   (ctl)
  );

  // Stack, slot store and counters.
  gah_datapath #(
    .SLOTS    (SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .cmd        (cmd),
    .slot_index (slot_index),
    .tag        (tag),
    .done       (done),
    .status     (status),
    .out_index  (out_index),
    .out_tag    (out_tag),
    .live       (live),
    .live_count (live_count)
  );

endmodule
